// ----- sv/rsc_pkg.sv -----
// Package: beat types, opcodes, constants and calendar helper functions.
`timescale 1ns / 1ps
package rsc_pkg;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_SET     = 1'b1;

  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned LAST_HOUR     = 23;
  localparam int unsigned MONTHS        = 12;

  // floor(v / 3600) = ((v >> 4) * HOUR_MUL) >> 36 for any 32-bit v
  localparam logic [28:0] HOUR_MUL   = 29'd305419897;
  // floor(q / 24) = ((q >> 3) * DAY_MUL) >> 20 for any 21-bit q
  localparam logic [18:0] DAY_MUL    = 19'd349526;
  // floor(r / 60) = ((r >> 2) * MIN_MUL) >> 14 for any r below 4096
  localparam logic [10:0] MIN_MUL    = 11'd1093;
  // n is a multiple of 25 iff (n * INV25) mod 4096 <= DIV25_LIMIT
  localparam logic [11:0] INV25       = 12'd3113;
  localparam logic [11:0] DIV25_LIMIT = 12'd163;

  typedef struct packed {
    logic        operation;
    logic [31:0] counter_value;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } cmd_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [16:0] counter_load;
  } res_t;

  typedef struct packed {
    logic        operation;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [16:0] load;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [11:0] rest;
  } split_t;

  function automatic logic is_leap(input logic [13:0] year);
    logic [11:0] residue;
    logic        div25;
    residue = year[13:2] * INV25;
    div25   = (residue <= DIV25_LIMIT);
    return (year[1:0] == 2'd0) && (!div25 || (year[3:2] == 2'd0));
  endfunction

  function automatic logic [4:0] month_days(input logic [13:0] year, input logic [3:0] month);
    logic [4:0] days;
    case (month)
      4'd2: begin
        days = is_leap(year) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        days = 5'd30;
      end
      default: begin
        days = 5'd31;
      end
    endcase
    return days;
  endfunction

endpackage

// ----- sv/rtc_seconds_to_calendar.sv -----
// Top level: seconds counter to calendar date and time converter.
// One beat per clock cycle is accepted and one result beat comes back for each. A convert
// beat splits the counter value into hour, minute and second through a four-register
// constant-divide pipeline; the stored date advances by one day when the hour goes from 23 to 0
// and is frozen while the stored year is 0. A set beat loads date and time as given and returns
// the seconds of day to write into the counter. The date update in the last stage sets the rate:
// it reads and writes the stored date once per beat. A result-side stall holds only the stages
// that hold a beat; empty stages still advance, so the input keeps accepting until every stage
// is full.
`timescale 1ns / 1ps
module rtc_seconds_to_calendar (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rsc_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output rsc_pkg::res_t res
);
  import rsc_pkg::*;

  logic   split_valid;
  logic   split_stall;
  split_t split;

  rsc_split u_split (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .split_valid (split_valid),
    .split_stall (split_stall),
    .split       (split)
  );

  rsc_date u_date (
    .clk         (clk),
    .rst         (rst),
    .split_valid (split_valid),
    .split_stall (split_stall),
    .split       (split),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

endmodule

// ----- sv/rsc_split.sv -----
// Pipelined split of a counter value into hour, minute and seconds remainder.
`timescale 1ns / 1ps
module rsc_split (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rsc_pkg::cmd_t cmd,
  output logic          split_valid,
  input  logic          split_stall,
  output rsc_pkg::split_t split
);
  import rsc_pkg::*;

  logic        s0_valid;
  cmd_t        s0;

  logic        s1_valid;
  cmd_t        s1;
  logic [20:0] s1_q;
  logic [16:0] s1_load;

  logic        s2_valid;
  cmd_t        s2;
  logic [16:0] s2_load;
  logic [11:0] s2_rest;
  logic [15:0] s2_hq;
  logic [4:0]  s2_q5;

  logic        s0_free;
  logic        s1_free;
  logic        s2_free;
  logic        s3_free;

  logic [56:0] q_prod;
  logic [16:0] load_next;
  logic [11:0] rest_next;
  logic [36:0] hq_prod;
  logic [20:0] min_prod;
  logic [5:0]  minute_next;
  logic [4:0]  hour_next;

  assign s3_free   = !split_valid || !split_stall;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign s0_free   = !s0_valid || s1_free;
  assign cmd_stall = !s0_free;

  always_comb begin
    q_prod    = 57'(s0.counter_value[31:4]) * 57'(HOUR_MUL);
    load_next = 17'(s0.set_hour) * 17'(SEC_PER_HOUR)
              + 17'(s0.set_minute) * 17'(SEC_PER_MIN)
              + 17'(s0.set_second);
  end

  always_comb begin
    rest_next = 12'(s1.counter_value - 32'(s1_q) * 32'(SEC_PER_HOUR));
    hq_prod   = 37'(s1_q[20:3]) * 37'(DAY_MUL);
  end

  always_comb begin
    min_prod    = 21'(s2_rest[11:2]) * 21'(MIN_MUL);
    minute_next = min_prod[19:14];
    hour_next   = s2_q5 - 5'(s2_hq * 16'(HOURS_PER_DAY));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid    <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      split_valid <= 1'b0;
    end else begin
      if (s0_free) s0_valid <= cmd_valid;
      if (s1_free) s1_valid <= s0_valid;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) split_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_free) begin
      s0 <= cmd;
    end
    if (s1_free) begin
      s1      <= s0;
      s1_q    <= q_prod[56:36];
      s1_load <= load_next;
    end
    if (s2_free) begin
      s2      <= s1;
      s2_load <= s1_load;
      s2_rest <= rest_next;
      s2_hq   <= hq_prod[35:20];
      s2_q5   <= s1_q[4:0];
    end
    if (s3_free) begin
      split.operation  <= s2.operation;
      split.set_year   <= s2.set_year;
      split.set_month  <= s2.set_month;
      split.set_day    <= s2.set_day;
      split.set_hour   <= s2.set_hour;
      split.set_minute <= s2.set_minute;
      split.set_second <= s2.set_second;
      split.load       <= s2_load;
      split.hour       <= hour_next;
      split.minute     <= minute_next;
      split.rest       <= s2_rest;
    end
  end

endmodule

// ----- sv/rsc_date.sv -----
// Stored date and time, day and month roll, and the result register.
`timescale 1ns / 1ps
module rsc_date (
  input  logic            clk,
  input  logic            rst,
  input  logic            split_valid,
  output logic            split_stall,
  input  rsc_pkg::split_t split,
  output logic            res_valid,
  input  logic            res_stall,
  output rsc_pkg::res_t   res
);
  import rsc_pkg::*;

  logic [13:0] date_year;
  logic [3:0]  date_month;
  logic [4:0]  date_day;
  logic [4:0]  time_hour;
  logic [5:0]  time_minute;
  logic [5:0]  time_second;
  logic [4:0]  last_hour;

  logic [13:0] date_year_next;
  logic [3:0]  date_month_next;
  logic [4:0]  date_day_next;
  logic [4:0]  time_hour_next;
  logic [5:0]  time_minute_next;
  logic [5:0]  time_second_next;
  logic [4:0]  last_hour_next;

  logic        take;
  logic [5:0]  second;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;

  assign split_stall = res_valid && res_stall;
  assign take        = split_valid && !split_stall;

  always_comb begin
    second           = 6'(split.rest - 12'(split.minute) * 12'(SEC_PER_MIN));
    day_inc          = 6'(date_day) + 6'd1;
    month_inc        = 5'(date_month) + 5'd1;
    date_year_next   = date_year;
    date_month_next  = date_month;
    date_day_next    = date_day;
    time_hour_next   = time_hour;
    time_minute_next = time_minute;
    time_second_next = time_second;
    last_hour_next   = last_hour;
    if (split.operation == OP_SET) begin
      date_year_next   = split.set_year;
      date_month_next  = split.set_month;
      date_day_next    = split.set_day;
      time_hour_next   = split.set_hour;
      time_minute_next = split.set_minute;
      time_second_next = split.set_second;
    end else begin
      time_hour_next   = split.hour;
      time_minute_next = split.minute;
      time_second_next = second;
      if (date_year != 14'd0) begin
        if ((split.hour == 5'd0) && (last_hour == 5'(LAST_HOUR))) begin
          if (day_inc > {1'b0, month_days(date_year, date_month)}) begin
            date_day_next = 5'd1;
            if (month_inc > 5'(MONTHS)) begin
              date_month_next = 4'd1;
              date_year_next  = date_year + 14'd1;
            end else begin
              date_month_next = month_inc[3:0];
            end
          end else begin
            date_day_next = day_inc[4:0];
          end
        end
        last_hour_next = split.hour;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      date_year   <= '0;
      date_month  <= '0;
      date_day    <= '0;
      time_hour   <= '0;
      time_minute <= '0;
      time_second <= '0;
      last_hour   <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (take) begin
        date_year   <= date_year_next;
        date_month  <= date_month_next;
        date_day    <= date_day_next;
        time_hour   <= time_hour_next;
        time_minute <= time_minute_next;
        time_second <= time_second_next;
        last_hour   <= last_hour_next;
      end
      if (!split_stall) res_valid <= split_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.cur_year     <= date_year_next;
      res.cur_month    <= date_month_next;
      res.cur_day      <= date_day_next;
      res.cur_hour     <= time_hour_next;
      res.cur_minute   <= time_minute_next;
      res.cur_second   <= time_second_next;
      res.counter_load <= (split.operation == OP_SET) ? split.load : 17'd0;
    end
  end

endmodule

// ----- bench/calendar_checker.sv -----
// Checker: predicts calendar results from accepted command beats and compares result beats.
`timescale 1ns / 1ps
module calendar_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  rsc_pkg::cmd_t     cmd,
  input  logic              res_valid,
  input  logic              res_stall,
  input  rsc_pkg::res_t     res,
  output int unsigned       errors,
  output int unsigned       waiting
);

  logic [13:0] stored_year;
  logic [3:0]  stored_month;
  logic [4:0]  stored_day;
  logic [4:0]  stored_hour;
  logic [5:0]  stored_minute;
  logic [5:0]  stored_second;
  logic [4:0]  hour_seen;

  rsc_pkg::res_t expected_dates[$];

  function automatic logic leap_year(input logic [13:0] y);
    int unsigned n;
    n = 32'(y);
    return (n % 4 == 0) && ((n % 100 != 0) || (n % 400 == 0));
  endfunction

  function automatic int unsigned days_of_month(input logic [13:0] y, input logic [3:0] m);
    int unsigned n;
    case (m)
      4'd2: begin
        n = leap_year(y) ? 29 : 28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        n = 30;
      end
      default: begin
        n = 31;
      end
    endcase
    return n;
  endfunction

  function automatic rsc_pkg::res_t next_calendar(input rsc_pkg::cmd_t c);
    rsc_pkg::res_t r;
    int unsigned   rest;
    int unsigned   next_day;
    int unsigned   load;
    load = 0;
    if (c.operation == rsc_pkg::OP_SET) begin
      stored_year   = c.set_year;
      stored_month  = c.set_month;
      stored_day    = c.set_day;
      stored_hour   = c.set_hour;
      stored_minute = c.set_minute;
      stored_second = c.set_second;
      load = stored_hour * rsc_pkg::SEC_PER_HOUR + stored_minute * rsc_pkg::SEC_PER_MIN
             + stored_second;
    end else begin
      rest          = c.counter_value % rsc_pkg::SEC_PER_HOUR;
      stored_hour   = 5'((c.counter_value / rsc_pkg::SEC_PER_HOUR) % rsc_pkg::HOURS_PER_DAY);
      stored_minute = 6'(rest / rsc_pkg::SEC_PER_MIN);
      stored_second = 6'(rest % rsc_pkg::SEC_PER_MIN);
      if (stored_year != 0) begin
        if (stored_hour == 0 && hour_seen == rsc_pkg::LAST_HOUR) begin
          next_day = stored_day + 1;
          if (next_day > days_of_month(stored_year, stored_month)) begin
            next_day = 1;
            if (stored_month >= rsc_pkg::MONTHS) begin
              stored_month = 4'd1;
              stored_year  = stored_year + 14'd1;
            end else begin
              stored_month = stored_month + 4'd1;
            end
          end
          stored_day = 5'(next_day);
        end
        hour_seen = stored_hour;
      end
    end
    r.cur_year     = stored_year;
    r.cur_month    = stored_month;
    r.cur_day      = stored_day;
    r.cur_hour     = stored_hour;
    r.cur_minute   = stored_minute;
    r.cur_second   = stored_second;
    r.counter_load = 17'(load);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    rsc_pkg::res_t want;
    if (rst) begin
      stored_year   = '0;
      stored_month  = '0;
      stored_day    = '0;
      stored_hour   = '0;
      stored_minute = '0;
      stored_second = '0;
      hour_seen     = '0;
      errors        = 0;
      expected_dates.delete();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        expected_dates.push_back(next_calendar(cmd));
      end
      if (res_valid && !res_stall) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result beat expected none actual %h", $time, res);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          check_field("cur_year", 32'(want.cur_year), 32'(res.cur_year));
          check_field("cur_month", 32'(want.cur_month), 32'(res.cur_month));
          check_field("cur_day", 32'(want.cur_day), 32'(res.cur_day));
          check_field("cur_hour", 32'(want.cur_hour), 32'(res.cur_hour));
          check_field("cur_minute", 32'(want.cur_minute), 32'(res.cur_minute));
          check_field("cur_second", 32'(want.cur_second), 32'(res.cur_second));
          check_field("counter_load", 32'(want.counter_load), 32'(res.counter_load));
        end
      end
    end
    waiting <= expected_dates.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Testbench top: drives calendar command beats with bursts and stalls and gives the verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned ITEMS        = 1350;
  localparam int unsigned DIRECTED     = 24;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned LAST_DAY_IDX = 49708;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic          clk;
  logic          rst;
  logic          cmd_valid;
  logic          cmd_stall;
  rsc_pkg::cmd_t cmd;
  logic          res_valid;
  logic          res_stall = 1'b0;
  rsc_pkg::res_t res;

  int unsigned   errors;
  int unsigned   waiting;
  int unsigned   sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   cycles = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int unsigned   stall_tick = 0;

  rtc_seconds_to_calendar i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  calendar_checker i_check (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .errors    (errors),
    .waiting   (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rtc_seconds_to_calendar test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_tick <= $urandom_range(20, 120);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      STALL_NONE: begin
        res_stall <= 1'b0;
      end
      STALL_LIGHT: begin
        res_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        res_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        res_stall <= stall_tick[2];
      end
    endcase
  end

  function automatic rsc_pkg::cmd_t noise_beat();
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    return noise[$bits(rsc_pkg::cmd_t)-1:0];
  endfunction

  function automatic rsc_pkg::cmd_t convert_beat(input logic [31:0] v);
    rsc_pkg::cmd_t c;
    c = noise_beat();
    c.operation     = rsc_pkg::OP_CONVERT;
    c.counter_value = v;
    return c;
  endfunction

  function automatic rsc_pkg::cmd_t set_beat(input int unsigned y, input int unsigned m,
                                             input int unsigned d, input int unsigned h,
                                             input int unsigned mi, input int unsigned s);
    rsc_pkg::cmd_t c;
    c = noise_beat();
    c.operation  = rsc_pkg::OP_SET;
    c.set_year   = 14'(y);
    c.set_month  = 4'(m);
    c.set_day    = 5'(d);
    c.set_hour   = 5'(h);
    c.set_minute = 6'(mi);
    c.set_second = 6'(s);
    return c;
  endfunction

  function automatic rsc_pkg::cmd_t random_date_beat(input int unsigned y);
    int unsigned d;
    d = $urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(1, 31);
    return set_beat(y, $urandom_range(1, 12), d, $urandom_range(0, 23),
                    $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  function automatic int unsigned pick_year();
    int unsigned edges[12] = '{1, 4, 100, 400, 1900, 2000, 2004, 2100, 2400,
                               16000, 16380, 16383};
    if ($urandom_range(0, 2) == 0) begin
      return edges[$urandom_range(0, 11)];
    end
    return $urandom_range(1, 16383);
  endfunction

  task automatic send_cmd(input rsc_pkg::cmd_t c);
    int unsigned gap;
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent++;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // walk across midnights: a few hours of the day, then hour 23, then hour 0 of the next day
  task automatic walk_days();
    int unsigned base;
    int unsigned ndays;
    int unsigned k;
    base  = $urandom_range(0, LAST_DAY_IDX - 8);
    ndays = $urandom_range(1, 8);
    for (k = 0; k < ndays; k++) begin
      repeat ($urandom_range(0, 3)) begin
        send_cmd(convert_beat((base + k) * SECS_PER_DAY + $urandom_range(0, 82799)));
      end
      send_cmd(convert_beat((base + k) * SECS_PER_DAY + 82800 + $urandom_range(0, 3599)));
      send_cmd(convert_beat((base + k + 1) * SECS_PER_DAY + $urandom_range(0, 3599)));
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned day_idx;
    logic        paused;
    paused    = 1'b0;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // date unknown: time only
    send_cmd(convert_beat(32'hFFFF_FFFF));
    send_cmd(convert_beat(32'd0));
    // leap century
    send_cmd(set_beat(2000, 2, 28, 23, 59, 59));
    send_cmd(convert_beat(86399));
    send_cmd(convert_beat(SECS_PER_DAY));
    send_cmd(convert_beat(2 * SECS_PER_DAY - 1));
    send_cmd(convert_beat(2 * SECS_PER_DAY));
    // non-leap century
    send_cmd(set_beat(1900, 2, 28, 0, 0, 0));
    send_cmd(convert_beat(23 * 3600));
    send_cmd(convert_beat(SECS_PER_DAY));
    // year wraps to zero, then the date freezes
    send_cmd(set_beat(16383, 12, 31, 23, 0, 0));
    send_cmd(convert_beat(23 * 3600));
    send_cmd(convert_beat(0));
    send_cmd(convert_beat(23 * 3600));
    send_cmd(convert_beat(0));
    // invalid month and day, out-of-range time fields
    send_cmd(set_beat(5, 15, 0, 31, 63, 63));
    send_cmd(convert_beat(23 * 3600));
    send_cmd(convert_beat(0));
    send_cmd(set_beat(7, 13, 31, 12, 0, 0));
    send_cmd(convert_beat(23 * 3600));
    send_cmd(convert_beat(0));
    // day beyond month length
    send_cmd(set_beat(2023, 4, 31, 0, 0, 0));
    send_cmd(convert_beat(23 * 3600));
    send_cmd(convert_beat(0));

    while (sent < ITEMS + DIRECTED) begin
      if (!paused && sent >= DIRECTED + ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_cmd(random_date_beat(pick_year()));
        walk_days();
      end else if (pick < 70) begin
        send_cmd(noise_beat() | {1'b1, {($bits(rsc_pkg::cmd_t) - 1){1'b0}}});
      end else if (pick < 80) begin
        send_cmd(convert_beat($urandom()));
      end else if (pick < 90) begin
        day_idx = $urandom_range(0, LAST_DAY_IDX);
        send_cmd(convert_beat(day_idx * SECS_PER_DAY + 82800 + $urandom_range(0, 3599)));
        send_cmd(convert_beat(day_idx * SECS_PER_DAY + $urandom_range(3600, 82799)));
      end else begin
        send_cmd(random_date_beat(0));
        walk_days();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("rtc_seconds_to_calendar test passed");
    end else begin
      $display("rtc_seconds_to_calendar test failed");
    end
    $finish;
  end

endmodule
